### design/twf_pkg.sv
// ----------------------------------------------------------------------------
// Twofish package
// Shared types, constants and GF(2^8), q and MDS helper functions.
// ----------------------------------------------------------------------------
package twf_pkg;

   localparam int SUBKEY_PAIRS = 20;
   localparam int PAIR_ADDR_W  = 5;

   localparam logic [8:0] POLY_MDS = 9'h169;
   localparam logic [8:0] POLY_RS  = 9'h14D;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_KEY_0_7    = 3'd0;
   localparam csr_index_type CSR_KEY_8_15   = 3'd1;
   localparam csr_index_type CSR_KEY_16_23  = 3'd2;
   localparam csr_index_type CSR_KEY_24_31  = 3'd3;
   localparam csr_index_type CSR_KEY_SIZE   = 3'd4;

   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;

   localparam logic ACTION_DECRYPT = 1'b1;

   typedef struct packed {
      logic        action;
      logic [63:0] block_low;
      logic [63:0] block_high;
   } twf_req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } twf_rsp_type;

   typedef logic [3:0][31:0] twf_words_type;

   typedef struct packed {
      logic                   en;
      logic [PAIR_ADDR_W-1:0] addr;
      logic [63:0]            data;
   } twf_ram_wr_type;

   typedef enum logic [3:0] {
      ST_KS_RS,
      ST_KS_H,
      ST_IDLE,
      ST_LOAD0,
      ST_LOAD1,
      ST_G0,
      ST_G1,
      ST_OUT0,
      ST_OUT1
   } twf_state_type;

   localparam logic [7:0] RS_MAT [4][8] = '{
      '{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
      '{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
      '{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
      '{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}};

   // Which q permutation each byte position uses at each stage.
   localparam logic Q_SEL [4][5] = '{
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}};

   localparam logic [3:0] Q_TAB [2][4][16] = '{
      '{'{4'h8, 4'h1, 4'h7, 4'hD, 4'h6, 4'hF, 4'h3, 4'h2,
          4'h0, 4'hB, 4'h5, 4'h9, 4'hE, 4'hC, 4'hA, 4'h4},
        '{4'hE, 4'hC, 4'hB, 4'h8, 4'h1, 4'h2, 4'h3, 4'h5,
          4'hF, 4'h4, 4'hA, 4'h6, 4'h7, 4'h0, 4'h9, 4'hD},
        '{4'hB, 4'hA, 4'h5, 4'hE, 4'h6, 4'hD, 4'h9, 4'h0,
          4'hC, 4'h8, 4'hF, 4'h3, 4'h2, 4'h4, 4'h7, 4'h1},
        '{4'hD, 4'h7, 4'hF, 4'h4, 4'h1, 4'h2, 4'h6, 4'hE,
          4'h9, 4'hB, 4'h3, 4'h0, 4'h8, 4'h5, 4'hC, 4'hA}},
      '{'{4'h2, 4'h8, 4'hB, 4'hD, 4'hF, 4'h7, 4'h6, 4'hE,
          4'h3, 4'h1, 4'h9, 4'h4, 4'h0, 4'hA, 4'hC, 4'h5},
        '{4'h1, 4'hE, 4'h2, 4'hB, 4'h4, 4'hC, 4'h3, 4'h7,
          4'h6, 4'hD, 4'hA, 4'h5, 4'hF, 4'h9, 4'h0, 4'h8},
        '{4'h4, 4'hC, 4'h7, 4'h5, 4'h1, 4'h6, 4'h9, 4'hA,
          4'h0, 4'hE, 4'hD, 4'h8, 4'h2, 4'hB, 4'h3, 4'hF},
        '{4'hB, 4'h9, 4'h5, 4'h1, 4'hC, 4'h3, 4'hD, 4'hE,
          4'h6, 4'h4, 4'h7, 4'hF, 4'h2, 4'h0, 4'h8, 4'hA}}};

   function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [8:0] poly);
      logic [8:0] bb;
      logic [7:0] acc;
      bb  = {1'b0, b};
      acc = '0;
      for (int n = 0; n < 8; n++) begin
         if (a[n]) begin
            acc = acc ^ bb[7:0];
         end
         bb = {bb[7:0], 1'b0};
         if (bb[8]) begin
            bb = bb ^ poly;
         end
      end
      return acc;
   endfunction

   function automatic logic [7:0] q_perm(input logic sel, input logic [7:0] x);
      logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
      a0 = x[7:4];
      b0 = x[3:0];
      a1 = a0 ^ b0;
      b1 = a0 ^ {b0[0], b0[3:1]} ^ {a0[0], 3'b000};
      a2 = Q_TAB[sel][0][a1];
      b2 = Q_TAB[sel][1][b1];
      a3 = a2 ^ b2;
      b3 = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b000};
      a4 = Q_TAB[sel][2][a3];
      b4 = Q_TAB[sel][3][b3];
      return {b4, a4};
   endfunction

   function automatic logic [31:0] mds_col(input logic [7:0] v, input logic [1:0] col);
      logic [7:0] m5, me;
      logic [31:0] res;
      m5 = gf_mul(v, 8'h5B, POLY_MDS);
      me = gf_mul(v, 8'hEF, POLY_MDS);
      case (col)
         2'd0:    res = {me, me, m5, v};
         2'd1:    res = {v, m5, me, me};
         2'd2:    res = {me, v, me, m5};
         default: res = {m5, me, v, m5};
      endcase
      return res;
   endfunction

endpackage

### design/twf_h_unit.sv
// ----------------------------------------------------------------------------
// Twofish h function unit
// Four q chains keyed by a list of words, followed by the MDS multiply.
// ----------------------------------------------------------------------------
module twf_h_unit (
   input  logic [31:0]           x,
   input  twf_pkg::twf_words_type l_words,
   input  logic [1:0]            first_stage,
   output logic [31:0]           h_out
);
   import twf_pkg::*;

   logic [7:0] v;
   logic [1:0] j;

   // The chain starts at first_stage; after every stage but the last the next key byte is mixed in.
   always_comb begin
      h_out = '0;
      v     = '0;
      j     = '0;
      for (int pos = 0; pos < 4; pos++) begin
         v = x[8*pos +: 8];
         for (int z = 0; z < 5; z++) begin
            j = 2'(z - 1 - int'(first_stage));
            if (z == int'(first_stage)) begin
               v = q_perm(Q_SEL[pos][z], v);
            end else if (z > int'(first_stage)) begin
               v = q_perm(Q_SEL[pos][z], v ^ l_words[j][8*pos +: 8]);
            end
         end
         h_out = h_out ^ mds_col(v, 2'(pos));
      end
   end

endmodule

### design/twf_subkey_ram.sv
// ----------------------------------------------------------------------------
// Twofish subkey memory
// Holds the round subkeys as pairs, odd subkey in the upper half.
// ----------------------------------------------------------------------------
module twf_subkey_ram (
   input  logic                                clock,
   input  twf_pkg::twf_ram_wr_type             wr,
   input  logic [twf_pkg::PAIR_ADDR_W-1:0]     rd_addr,
   output logic [63:0]                         rd_data
);
   import twf_pkg::*;

   logic [63:0] mem [SUBKEY_PAIRS];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/twofish_block_cipher.sv
// ----------------------------------------------------------------------------
// Twofish block cipher
// ECB encrypt and decrypt with 128, 192 or 256 bit keys over one shared h unit.
//
//   port group  direction  handshake       content
//   req_        in         valid / stall   action, 128-bit block
//   rsp_        out        valid / stall   128-bit result
//   csr_        in         valid / ready   key register index and data
//
// An item passes from acceptance through two whitening loads, sixteen rounds
// of two g evaluations each (the h unit serves one g per cycle) and two output
// whitening states to a valid result. The block goes back to idle to take the
// next item, so it takes no new item while one is in flight. After reset and
// after every key register write the key schedule runs (4 RS words, 40 h
// evaluations), during which no item is accepted. A stalled result holds the
// block in its final state until the result is taken.
// ----------------------------------------------------------------------------
module twofish_block_cipher (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  twf_pkg::twf_req_type   req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output twf_pkg::twf_rsp_type   rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  twf_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_data
);
   import twf_pkg::*;

   twf_state_type  state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [3:0][63:0] key_ff;
   logic [1:0]     key_size_ff;
   twf_words_type  sbox_ff, x_ff;
   logic [31:0]    t2_ff;
   logic           action_ff;
   twf_rsp_type    rsp_ff;
   logic           rsp_valid_ff;

   logic           csr_write, cfg_hit, req_accept, rsp_free, last_half;
   logic [2:0]     words;
   logic [1:0]     first_stage;
   twf_words_type  ks_l, unit_l;
   logic [31:0]    unit_x, unit_out, rs_word;
   logic [7:0]     rs_acc;
   logic [1:0]     key_word;
   logic [31:0]    ks_b, ks_sum, t1, s0, s1, n2, n3;
   logic [PAIR_ADDR_W-1:0] rd_addr;
   logic [63:0]    rd_data;
   twf_ram_wr_type ram_wr;

   assign csr_write  = csr_valid && csr_ready;
   assign cfg_hit    = csr_index <= CSR_KEY_SIZE;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign last_half  = cnt_ff[3:0] == 4'd15;

   always_comb begin
      unique case (key_size_ff)
         KEY_SIZE_128: words = 3'd2;
         KEY_SIZE_192: words = 3'd3;
         default:      words = 3'd4;
      endcase
   end
   assign first_stage = 2'(3'd4 - words);

   // RS code of one 64-bit key word per cycle.
   always_comb begin
      rs_word = '0;
      rs_acc  = '0;
      for (int r = 0; r < 4; r++) begin
         rs_acc = '0;
         for (int c = 0; c < 8; c++) begin
            rs_acc = rs_acc ^ gf_mul(key_ff[cnt_ff[1:0]][8*c +: 8], RS_MAT[r][c], POLY_RS);
         end
         rs_word[8*r +: 8] = rs_acc;
      end
      if ({1'b0, cnt_ff[1:0]} >= words) begin
         rs_word = '0;
      end
   end

   // Key words for the subkey h evaluations, last key word first.
   always_comb begin
      ks_l     = '0;
      key_word = '0;
      for (int j = 0; j < 4; j++) begin
         key_word = 2'(int'(words) - 1 - j);
         if (j < int'(words)) begin
            ks_l[j] = cnt_ff[0] ? key_ff[key_word][63:32] : key_ff[key_word][31:0];
         end
      end
   end

   // Output block: handshakes, h unit operands, memory read address.
   always_comb begin
      csr_ready = state_ff == ST_IDLE;
      req_stall = (state_ff != ST_IDLE) || csr_valid;
      unit_x    = rol32(x_ff[1], 8);
      unit_l    = sbox_ff;
      rd_addr   = '0;
      unique case (state_ff)
         ST_KS_H: begin
            unit_x = {4{2'b00, cnt_ff}};
            unit_l = ks_l;
         end
         ST_IDLE: begin
            rd_addr = (req_data.action == ACTION_DECRYPT) ? 5'd2 : 5'd0;
         end
         ST_LOAD0: begin
            rd_addr = (action_ff == ACTION_DECRYPT) ? 5'd3 : 5'd1;
         end
         ST_G0: begin
            rd_addr = (action_ff == ACTION_DECRYPT) ? 5'd19 - {1'b0, cnt_ff[3:0]}
                                                    : 5'd4 + {1'b0, cnt_ff[3:0]};
         end
         ST_G1: begin
            unit_x  = x_ff[0];
            rd_addr = (action_ff == ACTION_DECRYPT) ? 5'd0 : 5'd2;
         end
         ST_OUT0, ST_OUT1: begin
            rd_addr = (action_ff == ACTION_DECRYPT) ? 5'd1 : 5'd3;
         end
         default: begin
         end
      endcase
   end

   twf_h_unit u_h_unit (
      .x           (unit_x),
      .l_words     (unit_l),
      .first_stage (first_stage),
      .h_out       (unit_out)
   );

   assign ks_b   = rol32(unit_out, 8);
   assign ks_sum = t2_ff + ks_b;
   assign ram_wr = '{en:   (state_ff == ST_KS_H) && cnt_ff[0],
                     addr: cnt_ff[5:1],
                     data: {rol32(ks_sum + ks_b, 9), ks_sum}};

   twf_subkey_ram u_subkey_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Half round: words 0 and 1 feed g, words 2 and 3 are updated.
   assign t1 = unit_out + t2_ff;
   assign s0 = t1 + rd_data[31:0];
   assign s1 = t2_ff + t1 + rd_data[63:32];
   always_comb begin
      if (action_ff == ACTION_DECRYPT) begin
         n2 = rol32(x_ff[2], 1) ^ s0;
         n3 = ror32(x_ff[3] ^ s1, 1);
      end else begin
         n2 = ror32(x_ff[2] ^ s0, 1);
         n3 = rol32(x_ff[3], 1) ^ s1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_KS_RS: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = ST_KS_H;
               cnt_in   = '0;
            end
         end
         ST_KS_H: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(2 * SUBKEY_PAIRS - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (csr_write && cfg_hit) begin
               state_in = ST_KS_RS;
            end else if (req_accept) begin
               state_in = ST_LOAD0;
            end
         end
         ST_LOAD0: state_in = ST_LOAD1;
         ST_LOAD1: state_in = ST_G0;
         ST_G0:    state_in = ST_G1;
         ST_G1: begin
            cnt_in   = cnt_ff + 6'd1;
            state_in = last_half ? ST_OUT0 : ST_G0;
         end
         ST_OUT0: state_in = ST_OUT1;
         ST_OUT1: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KS_RS;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         key_ff       <= '0;
         key_size_ff  <= KEY_SIZE_128;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if ((state_ff == ST_OUT1) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_0_7:   key_ff[0]   <= csr_data;
               CSR_KEY_8_15:  key_ff[1]   <= csr_data;
               CSR_KEY_16_23: key_ff[2]   <= csr_data;
               CSR_KEY_24_31: key_ff[3]   <= csr_data;
               CSR_KEY_SIZE:  key_size_ff <= csr_data[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_KS_RS: sbox_ff[cnt_ff[1:0]] <= rs_word;
         ST_KS_H: begin
            if (!cnt_ff[0]) begin
               t2_ff <= unit_out;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               x_ff      <= {req_data.block_high, req_data.block_low};
               action_ff <= req_data.action;
            end
         end
         ST_LOAD0: begin
            x_ff[0] <= x_ff[0] ^ rd_data[31:0];
            x_ff[1] <= x_ff[1] ^ rd_data[63:32];
         end
         ST_LOAD1: begin
            x_ff[2] <= x_ff[2] ^ rd_data[31:0];
            x_ff[3] <= x_ff[3] ^ rd_data[63:32];
         end
         ST_G0: t2_ff <= unit_out;
         ST_G1: x_ff <= {x_ff[1], x_ff[0], n3, n2};
         ST_OUT0: begin
            x_ff[2] <= x_ff[2] ^ rd_data[31:0];
            x_ff[3] <= x_ff[3] ^ rd_data[63:32];
         end
         ST_OUT1: begin
            if (rsp_free) begin
               rsp_ff.result_low  <= {x_ff[3], x_ff[2]};
               rsp_ff.result_high <= {x_ff[1] ^ rd_data[63:32], x_ff[0] ^ rd_data[31:0]};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_item_starts_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_LOAD0)
      else $error("accepted item did not start the whitening load");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT1)
      else $error("result raised outside the final cycle");

   a_key_write_reschedules: assert property (@(posedge clock) disable iff (reset)
      (csr_write && cfg_hit) |=> state_ff == ST_KS_RS)
      else $error("key write did not restart the key schedule");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G0 || state_ff == ST_G1) |-> cnt_ff < 6'd16)
      else $error("round counter out of range");

endmodule

### tb/tb_twofish_block_cipher.sv
// ----------------------------------------------------------------------------
// Twofish block cipher testbench
// Drives random and directed blocks through the cipher under several keys and
// key sizes, predicts each result with a behavioral Twofish model and compares.
// ----------------------------------------------------------------------------
module tb_twofish_block_cipher;
   import twf_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   twf_req_type   req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   twf_rsp_type   rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [63:0]   csr_data;

   twofish_block_cipher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Model copy of the key registers and the derived schedule.
   logic [63:0] key_reg [4];
   logic [1:0]  key_len_code;
   logic [31:0] subkey [40];
   logic [7:0]  sbox_bytes [16];
   int          first_q_stage;

   twf_req_type block_queue [$];
   twf_rsp_type cipher_expected [$];
   int          mismatch_count;
   int          result_count;
   int          sent_count;
   int          encrypt_count;
   int          decrypt_count;
   bit          driver_hold;
   int          burst_left;
   int          gap_left;
   int          stall_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("Timeout with %0d results still expected", cipher_expected.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                            input logic [8:0] poly);
      logic [8:0] sh;
      logic [7:0] acc;
      sh  = {1'b0, b};
      acc = 8'h00;
      for (int n = 0; n < 8; n++) begin
         if (a[n]) acc ^= sh[7:0];
         sh = sh << 1;
         if (sh[8]) sh ^= poly;
      end
      return acc;
   endfunction

   function automatic logic [7:0] q_box(input logic sel, input logic [7:0] x);
      logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3;
      a0 = x[7:4];
      b0 = x[3:0];
      a1 = a0 ^ b0;
      b1 = a0 ^ {b0[0], b0[3:1]} ^ {a0[0], 3'b000};
      a2 = Q_TAB[sel][0][a1];
      b2 = Q_TAB[sel][1][b1];
      a3 = a2 ^ b2;
      b3 = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b000};
      return {Q_TAB[sel][3][b3], Q_TAB[sel][2][a3]};
   endfunction

   function automatic logic [31:0] mds_column(input logic [7:0] v, input int col);
      logic [7:0] m5, me;
      m5 = field_mul(v, 8'h5B, 9'h169);
      me = field_mul(v, 8'hEF, 9'h169);
      case (col)
         0: return {me, me, m5, v};
         1: return {v, m5, me, me};
         2: return {me, v, me, m5};
         default: return {m5, me, v, m5};
      endcase
   endfunction

   // Key-dependent q chain for one byte lane; mix[j] is applied after stage first_q_stage + j.
   function automatic logic [7:0] q_lane(input logic [7:0] x, input int lane,
                                         input logic [7:0] mix [4]);
      int stage;
      int j;
      stage = first_q_stage;
      j = 0;
      x = q_box(Q_SEL[lane][stage], x);
      while (stage < 4) begin
         x ^= mix[j];
         j++;
         stage++;
         x = q_box(Q_SEL[lane][stage], x);
      end
      return x;
   endfunction

   function automatic logic [31:0] g_func(input logic [31:0] x);
      logic [31:0] acc;
      logic [7:0]  mix [4];
      acc = 32'h0;
      for (int lane = 0; lane < 4; lane++) begin
         for (int j = 0; j < 4; j++) mix[j] = sbox_bytes[4 * j + lane];
         acc ^= mds_column(q_lane(x[8 * lane +: 8], lane, mix), lane);
      end
      return acc;
   endfunction

   task automatic expand_key();
      logic [7:0]  kb [32];
      logic [7:0]  mix [4];
      logic [7:0]  acc;
      logic [31:0] h [2];
      logic [31:0] a, b;
      int          words;
      words = (key_len_code == KEY_SIZE_128) ? 2 : (key_len_code == KEY_SIZE_192) ? 3 : 4;
      for (int n = 0; n < 32; n++)
         kb[n] = (n < 8 * words) ? key_reg[n / 8][8 * (n % 8) +: 8] : 8'h00;
      first_q_stage = 4 - words;
      for (int n = 0; n < 16; n++) sbox_bytes[n] = 8'h00;
      for (int w = 0; w < words; w++)
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int c = 0; c < 8; c++) acc ^= field_mul(kb[8 * w + c], RS_MAT[r][c], 9'h14D);
            sbox_bytes[4 * w + r] = acc;
         end
      for (int i = 0; i < 20; i++) begin
         for (int half = 0; half < 2; half++) begin
            h[half] = 32'h0;
            for (int lane = 0; lane < 4; lane++) begin
               for (int j = 0; j < 4; j++)
                  mix[j] = (j < words) ? kb[4 * (2 * (words - 1 - j) + half) + lane] : 8'h00;
               h[half] ^= mds_column(q_lane(8'(2 * i + half), lane, mix), lane);
            end
         end
         a = h[0];
         b = rotl(h[1], 8);
         subkey[2 * i]     = a + b;
         subkey[2 * i + 1] = rotl(a + b + b, 9);
      end
   endtask

   function automatic twf_rsp_type cipher_block(input twf_req_type item);
      logic [31:0] a, b, c, d, t1, t2;
      twf_rsp_type res;
      a = item.block_low[31:0];
      b = item.block_low[63:32];
      c = item.block_high[31:0];
      d = item.block_high[63:32];
      if (item.action != ACTION_DECRYPT) begin
         a ^= subkey[0]; b ^= subkey[1]; c ^= subkey[2]; d ^= subkey[3];
         for (int r = 0; r < 8; r++) begin
            t2 = g_func(rotl(b, 8));
            t1 = g_func(a) + t2;
            c = rotr(c ^ (t1 + subkey[8 + 4 * r]), 1);
            d = rotl(d, 1) ^ (t2 + t1 + subkey[9 + 4 * r]);
            t2 = g_func(rotl(d, 8));
            t1 = g_func(c) + t2;
            a = rotr(a ^ (t1 + subkey[10 + 4 * r]), 1);
            b = rotl(b, 1) ^ (t2 + t1 + subkey[11 + 4 * r]);
         end
         res.result_low  = {d ^ subkey[5], c ^ subkey[4]};
         res.result_high = {b ^ subkey[7], a ^ subkey[6]};
      end else begin
         {a, b, c, d} = {c ^ subkey[6], d ^ subkey[7], a ^ subkey[4], b ^ subkey[5]};
         for (int r = 0; r < 8; r++) begin
            t2 = g_func(rotl(d, 8));
            t1 = g_func(c) + t2;
            a = rotl(a, 1) ^ (t1 + subkey[38 - 4 * r]);
            b = rotr(b ^ (t2 + t1 + subkey[39 - 4 * r]), 1);
            t2 = g_func(rotl(b, 8));
            t1 = g_func(a) + t2;
            c = rotl(c, 1) ^ (t1 + subkey[36 - 4 * r]);
            d = rotr(d ^ (t2 + t1 + subkey[37 - 4 * r]), 1);
         end
         res.result_low  = {b ^ subkey[1], a ^ subkey[0]};
         res.result_high = {d ^ subkey[3], c ^ subkey[2]};
      end
      return res;
   endfunction

   // Register write through the csr channel; the model follows the write.
   task automatic write_key_reg(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_KEY_SIZE) key_len_code = value[1:0];
      else if (idx <= CSR_KEY_24_31) key_reg[idx] = value;
      expand_key();
   endtask

   task automatic wait_drained();
      wait (block_queue.size() == 0 && cipher_expected.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_value(input int pick);
      case (pick)
         0: return 64'h0;
         1: return '1;
         2: return 64'h8000_0000_0000_0001;
         3: return 64'h5555_5555_AAAA_AAAA;
         default: return rand64();
      endcase
   endfunction

   task automatic queue_block(input logic action, input logic [63:0] lo, input logic [63:0] hi);
      twf_req_type item;
      item.action     = action;
      item.block_low  = lo;
      item.block_high = hi;
      block_queue.push_back(item);
   endtask

   // Driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            cipher_expected.push_back(cipher_block(req_data));
            sent_count++;
            if (req_data.action == ACTION_DECRYPT) decrypt_count++;
            else encrypt_count++;
         end
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (block_queue.size() > 0 && !driver_hold) begin
            req_valid <= 1'b1;
            req_data  <= block_queue.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each taken result with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result %h", rsp_data);
            end else begin
               twf_rsp_type want;
               want = cipher_expected.pop_front();
               result_count++;
               if (rsp_data.result_low !== want.result_low ||
                   rsp_data.result_high !== want.result_high) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Result %0d: expected %h_%h, got %h_%h", result_count,
                              want.result_high, want.result_low,
                              rsp_data.result_high, rsp_data.result_low);
               end
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   initial begin
      logic [1:0] size_pick;
      mismatch_count = 0;
      result_count   = 0;
      sent_count     = 0;
      encrypt_count  = 0;
      decrypt_count  = 0;
      driver_hold    = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_0_7;
      csr_data  = 64'h0;
      for (int n = 0; n < 4; n++) key_reg[n] = 64'h0;
      key_len_code = KEY_SIZE_128;
      expand_key();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: all-zero key after reset, field extremes, both actions.
      for (int p = 0; p < 5; p++) begin
         queue_block(1'b0, edge_value(p), edge_value(4 - p));
         queue_block(1'b1, edge_value(p), edge_value(p));
      end
      wait_drained();
      // Full-size key with every byte set, then the unused size code three.
      for (int n = 0; n < 4; n++) write_key_reg(csr_index_type'(n), '1);
      write_key_reg(CSR_KEY_SIZE, 64'd2);
      queue_block(1'b0, 64'h0, 64'h0);
      queue_block(1'b1, '1, '1);
      wait_drained();
      write_key_reg(CSR_KEY_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_block(1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      queue_block(1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      wait_drained();
      // An index past the register list must change nothing.
      write_key_reg(csr_index_type'(3'd7), rand64());
      write_key_reg(CSR_KEY_SIZE, 64'd1);
      queue_block(1'b0, 64'h0, '1);
      queue_block(1'b1, '1, 64'h0);
      wait_drained();

      // Random phases: new key material and size, then a batch of blocks.
      for (int phase = 0; phase < 12; phase++) begin
         for (int n = 0; n < 4; n++)
            write_key_reg(csr_index_type'(n), (phase == 11) ? 64'h0 : rand64());
         size_pick = (phase < 3) ? 2'(phase) : 2'($urandom_range(0, 3));
         write_key_reg(CSR_KEY_SIZE, {62'($urandom()), size_pick});
         for (int i = 0; i < 72; i++)
            queue_block(1'($urandom_range(0, 1)), rand64(), rand64());
         // In phase five, halfway through its batch, the sender waits until every result is back.
         if (phase == 5) begin
            wait (block_queue.size() <= 36);
            driver_hold = 1'b1;
            wait (!req_valid && cipher_expected.size() == 0);
            repeat (5) @(posedge clock);
            driver_hold = 1'b0;
         end
         wait_drained();
      end

      wait_drained();
      $display("Checked %0d blocks (%0d encrypt, %0d decrypt) over key sizes 128, 192, 256",
               result_count, encrypt_count, decrypt_count);
      if (mismatch_count == 0 && cipher_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
